// ===== rtl/plc_pkg.sv =====
package plc_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > 7) ? CNT_W : 7;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] char_in;
        logic [6:0] position;
    } t_cmd;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] length;
        logic [7:0] read_char;
    } t_result;

    typedef struct packed {
        logic load;        // take the new byte
        logic take_left;   // shift up: take the lower neighbor
        logic take_right;  // shift down: take the upper neighbor
        logic sel;         // drive the read bus
    } t_cell_ctl;

endpackage

// ===== rtl/positional_char_list.sv =====
// Positional byte list of up to CAPACITY entries. A command transfers when
// start is high and busy is low; busy is held low, so a new command may be
// issued every clock cycle. Each command produces exactly one result, shown
// on o_result for one cycle with o_valid high, in the cycle after the command
// transfers. The receiver cannot stall: capture the result in that cycle or
// lose it. Storage is a row of byte cells, each able to take its lower or
// upper neighbor, so insert and delete shift every later entry in the same
// cycle; a read selects the addressed cell onto an OR bus. Stored bytes are
// not cleared by reset or by a clear command; only positions below the
// current length are ever reachable.
module positional_char_list
    import plc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_cmd    i_cmd,
    output logic    o_valid,
    output t_result o_result
);

    localparam int DATA_W = 8;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_valid;
    t_result          r_result;
    t_result          n_result;

    logic             w_accept;
    logic [CMP_W-1:0] w_pos;
    logic [CMP_W-1:0] w_cnt;
    logic [CMP_W-1:0] w_len;
    logic             w_ins_ok;
    logic             w_del_ok;
    logic             w_rd_ok;
    logic [1:0]       w_status;
    logic [7:0]       w_rd_bus;

    t_cell_ctl        w_ctl  [CAPACITY];
    logic [7:0]       w_data [CAPACITY];
    logic [7:0]       w_rd   [CAPACITY];

    // Never stall the command side
    assign busy     = 1'b0;
    assign w_accept = start & ~busy;

    assign w_pos = CMP_W'(i_cmd.position);
    assign w_cnt = CMP_W'(r_count);

    // Decide the outcome of the command against the current length
    always_comb begin
        w_ins_ok = 1'b0;
        w_del_ok = 1'b0;
        w_rd_ok  = 1'b0;
        w_status = ST_OK;
        n_count  = r_count;
        case (i_cmd.opcode)
            OP_INSERT: begin
                if (w_pos > w_cnt) begin
                    w_status = ST_RANGE;
                end else if (w_cnt >= CMP_W'(CAPACITY)) begin
                    w_status = ST_FULL;
                end else begin
                    w_ins_ok = 1'b1;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            OP_DELETE: begin
                if (w_pos >= w_cnt) begin
                    w_status = ST_RANGE;
                end else begin
                    w_del_ok = 1'b1;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            OP_READ: begin
                if (w_pos >= w_cnt) begin
                    w_status = ST_RANGE;
                end else begin
                    w_rd_ok = 1'b1;
                end
            end
            default: begin
                n_count = '0;
            end
        endcase
    end

    // Per-cell controls: shift up above the insert point, shift down from
    // the delete point, address the read position
    genvar k;
    generate
        for (k = 0; k < CAPACITY; k++) begin : g_cell
            logic [7:0] w_left;
            logic [7:0] w_right;

            always_comb begin
                w_ctl[k].load       = w_accept & w_ins_ok & (w_pos == CMP_W'(k));
                w_ctl[k].take_left  = w_accept & w_ins_ok & (w_pos < CMP_W'(k));
                w_ctl[k].take_right = w_accept & w_del_ok & (w_pos <= CMP_W'(k));
                w_ctl[k].sel        = w_pos == CMP_W'(k);
            end

            if (k == 0) begin : g_first
                assign w_left = w_data[k];
            end else begin : g_mid_l
                assign w_left = w_data[k-1];
            end

            // The top cell has no upper neighbor; it holds on delete
            if (k == CAPACITY - 1) begin : g_last
                assign w_right = w_data[k];
            end else begin : g_mid_r
                assign w_right = w_data[k+1];
            end

            plc_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl[k]),
                .i_new   (i_cmd.char_in),
                .i_left  (w_left),
                .i_right (w_right),
                .o_data  (w_data[k]),
                .o_rd    (w_rd[k])
            );
        end
    endgenerate

    // Merge the read bus: at most one cell drives nonzero
    always_comb begin
        w_rd_bus = '0;
        for (int j = 0; j < CAPACITY; j++) begin
            w_rd_bus = w_rd_bus | w_rd[j];
        end
    end

    assign w_len = CMP_W'(n_count);

    always_comb begin
        n_result.status    = w_status;
        n_result.length    = w_len[6:0];
        n_result.read_char = w_rd_ok ? w_rd_bus : DATA_W'(0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    // Hold the result payload for its strobe cycle
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== rtl/plc_cell.sv =====
module plc_cell
    import plc_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctl  i_ctl,
    input  logic [7:0] i_new,
    input  logic [7:0] i_left,
    input  logic [7:0] i_right,
    output logic [7:0] o_data,
    output logic [7:0] o_rd
);

    logic [7:0] r_data;
    logic [7:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.load) begin
            n_data = i_new;
        end else if (i_ctl.take_left) begin
            n_data = i_left;
        end else if (i_ctl.take_right) begin
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // Gate onto the shared read bus only when addressed
    assign o_rd   = i_ctl.sel ? r_data : 8'd0;

endmodule
